### rtl/core/rgbhsv_pkg.sv
// shared types, constants and the divider step for the rgb to hsv pipeline
// no dependencies; imported by every module of the block
package rgbhsv_pkg;

  localparam int QBITS = 8;   // quotient bits of both dividers
  localparam int RBITS = 17;  // dividend / partial remainder width
  localparam int DBITS = 9;   // divisor width

  typedef struct packed {
    logic [RBITS-1:0] rem;
    logic [DBITS-1:0] dvs;
    logic [QBITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t      hue_l;
    lane_t      sat_l;
    logic [7:0] bright;
  } div_item_t;

  // one restoring step, resolves quotient bit bit_pos
  function automatic lane_t div_step(input lane_t l, input logic [2:0] bit_pos);
    logic [RBITS-1:0] trial;
    lane_t            o;
    trial = RBITS'(l.dvs) << bit_pos;
    o = l;
    if (l.rem >= trial) begin
      o.rem          = l.rem - trial;
      o.quo[bit_pos] = 1'b1;
    end
    return o;
  endfunction

endpackage

### rtl/core/rgb_to_hsv_byte_scale.sv
// top level of the rgb to hsv converter: front end, divider pipeline, output register
// depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_divpipe
//
// converts one packed colour (red bits 7:0, green 15:8, blue 23:16) per transaction into
// hue, saturation and brightness on a 0..255 scale. brightness is the largest channel,
// saturation is 255 - floor(255*min/max), hue is floor(42.5*h) from the usual sextant
// formula, computed exactly; gray and black give hue 0, black gives saturation 0.
// the block is a 12-stage pipeline: three front stages (max/min, sextant numerator,
// dividend set-up), eight divider stages that each settle one quotient bit of both the
// hue and saturation dividers, and the output register. one transaction is accepted every
// cycle unless a stall at the output has backed up to the input; every stage holds
// its own valid bit and takes a new transaction whenever it is empty or its successor
// moves, so bubbles are squeezed out and a stalled output only backs up the stages behind
// it. in_ready depends combinationally on out_ready through the stage chain.
module rgb_to_hsv_byte_scale import rgbhsv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_packed_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_hue,
  output logic [7:0]  out_saturation,
  output logic [7:0]  out_brightness
);

  div_item_t front_item, div_item;
  logic      front_valid, front_ready;
  logic      div_valid, div_ready;

  logic       out_valid_r;
  logic [7:0] hue_r, sat_r, bright_r;
  logic [7:0] hue_nxt, sat_nxt;

  // max/min, numerator and dividends
  rgbhsv_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_packed_color (in_packed_color),
    .item_valid      (front_valid),
    .item_ready      (front_ready),
    .item            (front_item)
  );

  // both quotients, one bit a stage
  rgbhsv_divpipe u_divpipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  // output register takes a new transaction when empty or being drained
  assign div_ready = !out_valid_r || out_ready;

  // saturation is the complement of the min over max quotient
  assign hue_nxt = div_item.hue_l.quo;
  assign sat_nxt = 8'hFF - div_item.sat_l.quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= div_item.bright;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

  // an empty output stage means every stage behind it can move
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output stage");

  // black in gives zero hue and zero saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_brightness == 8'd0) |-> (out_saturation == 8'd0 && out_hue == 8'd0))
    else $error("black transaction with non-zero hue or saturation");

  // hue never reaches the full-circle code
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hue != 8'hFF))
    else $error("hue out of range");

endmodule

### rtl/core/rgbhsv_front.sv
// front end: channel unpack, max/min, sextant numerator and the dividend set-up
// three register stages; depends on rgbhsv_pkg
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_packed_color,
  output logic        item_valid,
  input  logic        item_ready,
  output div_item_t   item
);

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;
  localparam logic [16:0] MUL_HUE  = 17'd85;
  localparam logic [16:0] MUL_SAT  = 17'd255;

  // stage a
  logic       va_r;
  logic [7:0] ra_r, ga_r, ba_r, mxa_r, mna_r;
  logic [1:0] sela_r;
  logic [7:0] r_in, g_in, b_in, mxa_nxt, mna_nxt;
  logic [1:0] sela_nxt;
  // stage b
  logic        vb_r;
  logic [10:0] numb_r, numb_nxt;
  logic [7:0]  deltab_r, deltab_nxt, mxb_r, mnb_r;
  logic signed [11:0] num_s, dlt_s;
  // stage c
  logic      vc_r;
  div_item_t itemc_r, itemc_nxt;

  logic ready_a, ready_b, ready_c;

  assign ready_c  = !vc_r || item_ready;
  assign ready_b  = !vb_r || ready_c;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  assign r_in = in_packed_color[7:0];
  assign g_in = in_packed_color[15:8];
  assign b_in = in_packed_color[23:16];

  always_comb begin
    mxa_nxt = (r_in > g_in) ? r_in : g_in;
    if (b_in > mxa_nxt) mxa_nxt = b_in;
    mna_nxt = (r_in < g_in) ? r_in : g_in;
    if (b_in < mna_nxt) mna_nxt = b_in;
    // ties: red over green over blue
    if (r_in == mxa_nxt) begin
      sela_nxt = SEL_RED;
    end else if (g_in == mxa_nxt) begin
      sela_nxt = SEL_GREEN;
    end else begin
      sela_nxt = SEL_BLUE;
    end
  end

  always_comb begin
    deltab_nxt = mxa_r - mna_r;
    dlt_s      = $signed({4'b0, deltab_nxt});
    case (sela_r)
      SEL_RED:   num_s = $signed({4'b0, ga_r}) - $signed({4'b0, ba_r});
      SEL_GREEN: num_s = 12'sd2 * dlt_s + $signed({4'b0, ba_r}) - $signed({4'b0, ra_r});
      default:   num_s = 12'sd4 * dlt_s + $signed({4'b0, ra_r}) - $signed({4'b0, ga_r});
    endcase
    if (num_s < 12'sd0) num_s = num_s + 12'sd6 * dlt_s;
    numb_nxt = 11'(num_s);
  end

  always_comb begin
    itemc_nxt.hue_l.rem = 17'(17'(numb_r) * MUL_HUE);
    itemc_nxt.hue_l.quo = '0;
    // gray or black: 0 over 1 gives hue 0
    if (deltab_r == 8'd0) begin
      itemc_nxt.hue_l.rem = '0;
      itemc_nxt.hue_l.dvs = 9'd1;
    end else begin
      itemc_nxt.hue_l.dvs = {deltab_r, 1'b0};
    end
    // black divides 0 by 0: all-ones quotient, so saturation comes out 0
    itemc_nxt.sat_l.rem = 17'(17'(mnb_r) * MUL_SAT);
    itemc_nxt.sat_l.dvs = {1'b0, mxb_r};
    itemc_nxt.sat_l.quo = '0;
    itemc_nxt.bright    = mxb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
      if (ready_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      ra_r   <= r_in;
      ga_r   <= g_in;
      ba_r   <= b_in;
      mxa_r  <= mxa_nxt;
      mna_r  <= mna_nxt;
      sela_r <= sela_nxt;
    end
    if (ready_b) begin
      numb_r   <= numb_nxt;
      deltab_r <= deltab_nxt;
      mxb_r    <= mxa_r;
      mnb_r    <= mna_r;
    end
    if (ready_c) itemc_r <= itemc_nxt;
  end

  assign item_valid = vc_r;
  assign item       = itemc_r;

endmodule

### rtl/core/rgbhsv_divpipe.sv
// pipelined restoring dividers for hue and saturation, one quotient bit per stage
// depends on rgbhsv_pkg
module rgbhsv_divpipe import rgbhsv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  logic      v_r   [QBITS];
  logic      rdy   [QBITS];
  div_item_t st_r  [QBITS];
  div_item_t st_nxt[QBITS];

  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    localparam logic [2:0] BIT_POS = 3'(QBITS - 1 - i);
    div_item_t src;
    logic      src_v;

    if (i == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st_r[i-1];
      assign src_v = v_r[i-1];
    end

    if (i == QBITS - 1) begin : g_last
      assign rdy[i] = !v_r[i] || out_ready;
    end else begin : g_mid
      assign rdy[i] = !v_r[i] || rdy[i+1];
    end

    always_comb begin
      st_nxt[i]        = src;
      st_nxt[i].hue_l  = div_step(src.hue_l, BIT_POS);
      st_nxt[i].sat_l  = div_step(src.sat_l, BIT_POS);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) st_r[i] <= st_nxt[i];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QBITS-1];
  assign out_item  = st_r[QBITS-1];

  // hue divisor is never zero, so the final remainder sits below it
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QBITS-1] |-> (st_r[QBITS-1].hue_l.rem < RBITS'(st_r[QBITS-1].hue_l.dvs)))
    else $error("hue remainder not below divisor");

endmodule
